### hw/rtl/assert_macros.svh
// Concurrent assertion helpers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, cond, prop, msg)
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

### hw/rtl/racst_pkg.sv
package racst_pkg;
   localparam int MAX_ELEMENTS = 1024;
   localparam int NODE_DEPTH   = 2 * MAX_ELEMENTS;
   localparam int ADDR_W       = $clog2(NODE_DEPTH);
   localparam int NODE_W       = ADDR_W + 1;
   localparam int REQ_IDX_W    = 10;
   localparam int IDX_W        = ($clog2(MAX_ELEMENTS) > REQ_IDX_W) ?
                                 $clog2(MAX_ELEMENTS) : REQ_IDX_W;
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
   localparam int CSR_W        = 11;
   localparam int VAL_W        = 30;
   localparam int TYPE_W       = 2;
   localparam int STACK_D      = $clog2(MAX_ELEMENTS) + 1;
   localparam int SP_W         = $clog2(STACK_D + 1);
   localparam int STK_IX_W     = $clog2(STACK_D);
   localparam int MUL_CNT_W    = $clog2(VAL_W);
   localparam logic [VAL_W-1:0] PRIME = 30'd1000000007;

   typedef enum logic [TYPE_W-1:0] {
      REQ_LOAD  = 2'd0,
      REQ_ADD   = 2'd1,
      REQ_QUERY = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic {OP_ADD, OP_MUL} op_type;

   typedef enum logic [3:0] {
      SEL_X, SEL_S1, SEL_S2, SEL_S3, SEL_LEN, SEL_X2, SEL_X3,
      SEL_T, SEL_U, SEL_K2, SEL_K3, SEL_ZERO, SEL_OPV
   } reg_sel_type;

   typedef struct packed {
      op_type      op;
      reg_sel_type a;
      reg_sel_type b;
      reg_sel_type dst;
   } uop_type;

   typedef enum logic {PEND_ZERO, PEND_ADD} pend_sel_type;

   localparam int UPC_W = 5;
   localparam logic [UPC_W-1:0] UPC_APPLY     = 5'd0;
   localparam logic [UPC_W-1:0] UPC_APPLY_END = 5'd16;
   localparam logic [UPC_W-1:0] UPC_LOAD      = 5'd17;
   localparam logic [UPC_W-1:0] UPC_LOAD_END  = 5'd19;
   localparam logic [UPC_W-1:0] UPC_SETX      = 5'd20;

   typedef struct packed {
      logic               capture;
      logic               rd;
      logic [ADDR_W-1:0]  rd_addr;
      logic               wr_sums;
      logic               wr_pend;
      logic               wr_zero;
      logic [ADDR_W-1:0]  wr_addr;
      pend_sel_type       pend_sel;
      logic               load_node;
      logic               add_sums;
      logic               acc_add;
      logic               uop_start;
      uop_type            uop;
      logic [VAL_W-1:0]   len;
   } dp_cmd_type;

   typedef struct packed {
      logic uop_done;
      logic x_zero;
   } dp_stat_type;

   function automatic logic [VAL_W-1:0] madd(input logic [VAL_W-1:0] a,
                                             input logic [VAL_W-1:0] b);
      logic [VAL_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, PRIME}) s = s - {1'b0, PRIME};
      return s[VAL_W-1:0];
   endfunction

   // apply: cube, square, value sums by binomial expansion; load; set addend
   function automatic uop_type uop_at(input logic [UPC_W-1:0] pc);
      uop_type u;
      unique case (pc)
         5'd0:    u = '{op: OP_MUL, a: SEL_X,    b: SEL_X,    dst: SEL_X2};
         5'd1:    u = '{op: OP_MUL, a: SEL_X2,   b: SEL_X,    dst: SEL_X3};
         5'd2:    u = '{op: OP_MUL, a: SEL_K3,   b: SEL_X,    dst: SEL_T};
         5'd3:    u = '{op: OP_MUL, a: SEL_T,    b: SEL_S2,   dst: SEL_T};
         5'd4:    u = '{op: OP_MUL, a: SEL_K3,   b: SEL_S1,   dst: SEL_U};
         5'd5:    u = '{op: OP_MUL, a: SEL_U,    b: SEL_X2,   dst: SEL_U};
         5'd6:    u = '{op: OP_ADD, a: SEL_T,    b: SEL_U,    dst: SEL_T};
         5'd7:    u = '{op: OP_MUL, a: SEL_LEN,  b: SEL_X3,   dst: SEL_U};
         5'd8:    u = '{op: OP_ADD, a: SEL_T,    b: SEL_U,    dst: SEL_T};
         5'd9:    u = '{op: OP_ADD, a: SEL_S3,   b: SEL_T,    dst: SEL_S3};
         5'd10:   u = '{op: OP_MUL, a: SEL_K2,   b: SEL_S1,   dst: SEL_T};
         5'd11:   u = '{op: OP_MUL, a: SEL_T,    b: SEL_X,    dst: SEL_T};
         5'd12:   u = '{op: OP_MUL, a: SEL_LEN,  b: SEL_X2,   dst: SEL_U};
         5'd13:   u = '{op: OP_ADD, a: SEL_T,    b: SEL_U,    dst: SEL_T};
         5'd14:   u = '{op: OP_ADD, a: SEL_S2,   b: SEL_T,    dst: SEL_S2};
         5'd15:   u = '{op: OP_MUL, a: SEL_LEN,  b: SEL_X,    dst: SEL_U};
         5'd16:   u = '{op: OP_ADD, a: SEL_S1,   b: SEL_U,    dst: SEL_S1};
         5'd17:   u = '{op: OP_ADD, a: SEL_OPV,  b: SEL_ZERO, dst: SEL_S1};
         5'd18:   u = '{op: OP_MUL, a: SEL_OPV,  b: SEL_OPV,  dst: SEL_S2};
         5'd19:   u = '{op: OP_MUL, a: SEL_OPV,  b: SEL_S2,   dst: SEL_S3};
         5'd20:   u = '{op: OP_ADD, a: SEL_OPV,  b: SEL_ZERO, dst: SEL_X};
         default: u = '{op: OP_ADD, a: SEL_ZERO, b: SEL_ZERO, dst: SEL_ZERO};
      endcase
      return u;
   endfunction
endpackage

### hw/rtl/racst_modmul.sv
module racst_modmul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [racst_pkg::VAL_W-1:0] a,
   input  logic [racst_pkg::VAL_W-1:0] b,
   output logic                       done,
   output logic [racst_pkg::VAL_W-1:0] product
);
   import racst_pkg::*;

   // bit-serial interleaved multiply, MSB of b first
   logic [VAL_W-1:0]     a_ff, b_ff, acc_ff, acc_in;
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic                 busy_ff, done_ff;
   logic [VAL_W:0]       dbl, dbl_red;
   logic [VAL_W-1:0]     addend;

   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, PRIME}) ? dbl - {1'b0, PRIME} : dbl;
      addend  = b_ff[VAL_W-1] ? a_ff : '0;
      acc_in  = madd(dbl_red[VAL_W-1:0], addend);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= MUL_CNT_W'(VAL_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         b_ff   <= {b_ff[VAL_W-2:0], 1'b0};
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

### hw/rtl/racst_datapath.sv
module racst_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  racst_pkg::dp_cmd_type       cmd,
   input  logic [racst_pkg::VAL_W-1:0] operand,
   output racst_pkg::dp_stat_type      stat,
   output logic [racst_pkg::VAL_W-1:0] cube_sum
);
   import racst_pkg::*;

   logic [VAL_W-1:0] s1_mem [NODE_DEPTH];
   logic [VAL_W-1:0] s2_mem [NODE_DEPTH];
   logic [VAL_W-1:0] s3_mem [NODE_DEPTH];
   logic [VAL_W-1:0] pend_mem [NODE_DEPTH];

   logic [VAL_W-1:0] rd_s1_ff, rd_s2_ff, rd_s3_ff, rd_pend_ff;
   logic [VAL_W-1:0] x_ff, s1_ff, s2_ff, s3_ff, x2_ff, x3_ff, t_ff, u_ff;
   logic [VAL_W-1:0] opv_ff, acc_ff;
   uop_type          uop_ff;
   logic             uop_done_ff;

   logic [VAL_W-1:0] a_val, b_val, add_val, wr_val, pend_wdata;
   logic [VAL_W-1:0] s1_w, s2_w, s3_w;
   logic             mm_done, wr_en, add_start;
   logic [VAL_W-1:0] mm_product;
   reg_sel_type      wr_dst;

   racst_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.uop_start && cmd.uop.op == OP_MUL),
      .a       (a_val),
      .b       (b_val),
      .done    (mm_done),
      .product (mm_product)
   );

   always_comb begin
      case (cmd.uop.a)
         SEL_X:   a_val = x_ff;
         SEL_S1:  a_val = s1_ff;
         SEL_S2:  a_val = s2_ff;
         SEL_S3:  a_val = s3_ff;
         SEL_LEN: a_val = cmd.len;
         SEL_X2:  a_val = x2_ff;
         SEL_X3:  a_val = x3_ff;
         SEL_T:   a_val = t_ff;
         SEL_U:   a_val = u_ff;
         SEL_K2:  a_val = VAL_W'(2);
         SEL_K3:  a_val = VAL_W'(3);
         SEL_OPV: a_val = opv_ff;
         default: a_val = '0;
      endcase
      case (cmd.uop.b)
         SEL_X:   b_val = x_ff;
         SEL_S1:  b_val = s1_ff;
         SEL_S2:  b_val = s2_ff;
         SEL_S3:  b_val = s3_ff;
         SEL_LEN: b_val = cmd.len;
         SEL_X2:  b_val = x2_ff;
         SEL_X3:  b_val = x3_ff;
         SEL_T:   b_val = t_ff;
         SEL_U:   b_val = u_ff;
         SEL_K2:  b_val = VAL_W'(2);
         SEL_K3:  b_val = VAL_W'(3);
         SEL_OPV: b_val = opv_ff;
         default: b_val = '0;
      endcase
      add_val   = madd(a_val, b_val);
      add_start = cmd.uop_start && cmd.uop.op == OP_ADD;
      if (add_start) begin
         wr_en  = 1'b1;
         wr_dst = cmd.uop.dst;
         wr_val = add_val;
      end else begin
         wr_en  = mm_done;
         wr_dst = uop_ff.dst;
         wr_val = mm_product;
      end
      pend_wdata = (cmd.pend_sel == PEND_ADD) ? madd(rd_pend_ff, x_ff) : '0;
      s1_w = cmd.wr_zero ? '0 : s1_ff;
      s2_w = cmd.wr_zero ? '0 : s2_ff;
      s3_w = cmd.wr_zero ? '0 : s3_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_zero || cmd.wr_sums) s1_mem[cmd.wr_addr] <= s1_w;
      if (cmd.rd) rd_s1_ff <= s1_mem[cmd.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_zero || cmd.wr_sums) s2_mem[cmd.wr_addr] <= s2_w;
      if (cmd.rd) rd_s2_ff <= s2_mem[cmd.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_zero || cmd.wr_sums) s3_mem[cmd.wr_addr] <= s3_w;
      if (cmd.rd) rd_s3_ff <= s3_mem[cmd.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_zero) begin
         pend_mem[cmd.wr_addr] <= '0;
      end else if (cmd.wr_pend) begin
         pend_mem[cmd.wr_addr] <= pend_wdata;
      end
      if (cmd.rd) rd_pend_ff <= pend_mem[cmd.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uop_done_ff <= 1'b0;
      end else begin
         uop_done_ff <= add_start || mm_done;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         opv_ff <= (operand >= PRIME) ? operand - PRIME : operand;
         acc_ff <= '0;
      end
      if (cmd.acc_add) acc_ff <= madd(acc_ff, s3_ff);
      if (cmd.uop_start) uop_ff <= cmd.uop;
      if (cmd.load_node) begin
         s1_ff <= rd_s1_ff;
         s2_ff <= rd_s2_ff;
         s3_ff <= rd_s3_ff;
         x_ff  <= rd_pend_ff;
      end
      if (cmd.add_sums) begin
         s1_ff <= madd(s1_ff, rd_s1_ff);
         s2_ff <= madd(s2_ff, rd_s2_ff);
         s3_ff <= madd(s3_ff, rd_s3_ff);
      end
      if (wr_en) begin
         case (wr_dst)
            SEL_X:   x_ff  <= wr_val;
            SEL_S1:  s1_ff <= wr_val;
            SEL_S2:  s2_ff <= wr_val;
            SEL_S3:  s3_ff <= wr_val;
            SEL_X2:  x2_ff <= wr_val;
            SEL_X3:  x3_ff <= wr_val;
            SEL_T:   t_ff  <= wr_val;
            SEL_U:   u_ff  <= wr_val;
            default: ;
         endcase
      end
   end

   assign stat.uop_done = uop_done_ff;
   assign stat.x_zero   = (x_ff == '0);
   assign cube_sum      = acc_ff;
endmodule

### hw/rtl/racst_ctrl.sv
module racst_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [racst_pkg::TYPE_W-1:0]    req_type,
   input  logic [racst_pkg::REQ_IDX_W-1:0] req_left_index,
   input  logic [racst_pkg::REQ_IDX_W-1:0] req_right_index,
   input  logic                            csr_we,
   input  logic [racst_pkg::CSR_W-1:0]     csr_wdata,
   input  racst_pkg::dp_stat_type          stat,
   output racst_pkg::dp_cmd_type           cmd,
   output logic                            rsp_valid
);
   import racst_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_ENTER, S_RD, S_LOADN, S_UOP, S_UWAIT, S_WB,
      S_CP_A, S_CP_B, S_CP_C, S_CHECK, S_SETX, S_LDWB, S_RET,
      S_CMB_A, S_CMB_B, S_CMB_C, S_CMB_D, S_DONE
   } state_type;

   state_type         state_ff, state_in, next_ff, next_in;
   req_kind_type      kind_ff, kind_in, req_kind;
   logic [IDX_W-1:0]  l_ff, l_in, r_ff, r_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [NODE_W-1:0] nd_ff, nd_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              covered_ff, covered_in, rsp_valid_ff, rsp_valid_in;
   logic [SP_W-1:0]   sp_ff, sp_in, sp_m1;
   logic [UPC_W-1:0]  pc_ff, pc_in, end_ff, end_in;
   logic [NODE_W-1:0] stk_nd_ff [STACK_D];
   logic [IDX_W-1:0]  stk_lo_ff [STACK_D];
   logic [IDX_W-1:0]  stk_hi_ff [STACK_D];
   logic              stk_ph_ff [STACK_D];
   logic              push, ph_set;

   logic [IDX_W-1:0]    top, req_l, req_r, mid, t_lo, t_hi, t_mid;
   logic [IDX_W:0]      mid_sum, t_sum;
   logic [NODE_W-1:0]   child_a, child_b, t_nd, t_child_b;
   logic [STK_IX_W-1:0] top_ix, push_ix;
   logic                in_store, has_kids, leaf, disjoint, covered;
   logic [CSR_W-1:0]    csr_v;

   always_comb begin
      top       = IDX_W'(count_ff - 1'b1);
      req_l     = IDX_W'(req_left_index);
      req_r     = IDX_W'(req_right_index);
      req_kind  = req_kind_type'(req_type);
      mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
      mid       = mid_sum[IDX_W:1];
      child_a   = {nd_ff[NODE_W-2:0], 1'b0};
      child_b   = {nd_ff[NODE_W-2:0], 1'b1};
      in_store  = nd_ff < NODE_W'(NODE_DEPTH);
      has_kids  = nd_ff < NODE_W'(MAX_ELEMENTS);
      leaf      = (lo_ff == hi_ff);
      disjoint  = (lo_ff > r_ff) || (hi_ff < l_ff);
      covered   = (lo_ff >= l_ff) && (hi_ff <= r_ff);
      sp_m1     = sp_ff - 1'b1;
      top_ix    = sp_m1[STK_IX_W-1:0];
      push_ix   = sp_ff[STK_IX_W-1:0];
      t_nd      = stk_nd_ff[top_ix];
      t_lo      = stk_lo_ff[top_ix];
      t_hi      = stk_hi_ff[top_ix];
      t_sum     = {1'b0, t_lo} + {1'b0, t_hi};
      t_mid     = t_sum[IDX_W:1];
      t_child_b = {t_nd[NODE_W-2:0], 1'b1};
      csr_v     = csr_wdata;
   end

   always_comb begin
      state_in     = state_ff;
      next_in      = next_ff;
      kind_in      = kind_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      nd_in        = nd_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      covered_in   = covered_ff;
      sp_in        = sp_ff;
      pc_in        = pc_ff;
      end_in       = end_ff;
      push         = 1'b0;
      ph_set       = 1'b0;
      rsp_valid_in = (state_ff == S_DONE) && (kind_ff == REQ_QUERY);

      cmd           = '0;
      cmd.rd_addr   = nd_ff[ADDR_W-1:0];
      cmd.wr_addr   = nd_ff[ADDR_W-1:0];
      cmd.pend_sel  = PEND_ZERO;
      cmd.uop       = uop_at(pc_ff);
      cmd.len       = VAL_W'(hi_ff - lo_ff) + VAL_W'(1);

      unique case (state_ff)
         S_CLEAR: begin
            cmd.wr_zero = 1'b1;
            cmd.wr_addr = clr_ff;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(NODE_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               kind_in     = req_kind;
               l_in        = req_l;
               r_in        = (req_kind == REQ_LOAD) ? req_l : req_r;
               nd_in       = NODE_W'(1);
               lo_in       = '0;
               hi_in       = top;
               sp_in       = '0;
               unique case (req_kind)
                  REQ_LOAD:             state_in = (req_l <= top) ? S_ENTER : S_DONE;
                  REQ_ADD, REQ_QUERY:   state_in = (req_l <= req_r) ? S_ENTER : S_DONE;
                  REQ_NONE:             state_in = S_DONE;
                  default:              state_in = S_DONE;
               endcase
            end
         end
         S_ENTER: begin
            covered_in = 1'b0;
            if (!in_store) begin
               state_in = S_RET;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.load_node = 1'b1;
            state_in      = S_LOADN;
         end
         S_LOADN: begin
            if (stat.x_zero) begin
               state_in = S_CHECK;
            end else begin
               pc_in    = UPC_APPLY;
               end_in   = UPC_APPLY_END;
               next_in  = S_WB;
               state_in = S_UOP;
            end
         end
         S_UOP: begin
            cmd.uop_start = 1'b1;
            state_in      = S_UWAIT;
         end
         S_UWAIT: begin
            if (stat.uop_done) begin
               if (pc_ff == end_ff) begin
                  state_in = next_ff;
               end else begin
                  pc_in    = pc_ff + 1'b1;
                  state_in = S_UOP;
               end
            end
         end
         S_WB: begin
            cmd.wr_sums = 1'b1;
            cmd.wr_pend = 1'b1;
            if (!leaf && has_kids) state_in = S_CP_A;
            else state_in = covered_ff ? S_RET : S_CHECK;
         end
         S_CP_A: begin
            cmd.rd      = 1'b1;
            cmd.rd_addr = child_a[ADDR_W-1:0];
            state_in    = S_CP_B;
         end
         S_CP_B: begin
            cmd.wr_pend  = 1'b1;
            cmd.pend_sel = PEND_ADD;
            cmd.wr_addr  = child_a[ADDR_W-1:0];
            cmd.rd       = 1'b1;
            cmd.rd_addr  = child_b[ADDR_W-1:0];
            state_in     = S_CP_C;
         end
         S_CP_C: begin
            cmd.wr_pend  = 1'b1;
            cmd.pend_sel = PEND_ADD;
            cmd.wr_addr  = child_b[ADDR_W-1:0];
            state_in     = covered_ff ? S_RET : S_CHECK;
         end
         S_CHECK: begin
            if (disjoint) begin
               state_in = S_RET;
            end else if (covered) begin
               unique case (kind_ff)
                  REQ_QUERY: begin
                     cmd.acc_add = 1'b1;
                     state_in    = S_RET;
                  end
                  REQ_LOAD: begin
                     pc_in    = UPC_LOAD;
                     end_in   = UPC_LOAD_END;
                     next_in  = S_LDWB;
                     state_in = S_UOP;
                  end
                  REQ_ADD: begin
                     pc_in    = UPC_SETX;
                     end_in   = UPC_SETX;
                     next_in  = S_SETX;
                     state_in = S_UOP;
                  end
                  default: state_in = S_RET;
               endcase
            end else if (!has_kids) begin
               state_in = S_RET;
            end else begin
               push     = 1'b1;
               sp_in    = sp_ff + 1'b1;
               nd_in    = child_a;
               hi_in    = mid;
               state_in = S_ENTER;
            end
         end
         S_SETX: begin
            if (stat.x_zero) begin
               state_in = S_RET;
            end else begin
               covered_in = 1'b1;
               pc_in      = UPC_APPLY;
               end_in     = UPC_APPLY_END;
               next_in    = S_WB;
               state_in   = S_UOP;
            end
         end
         S_LDWB: begin
            cmd.wr_sums = 1'b1;
            state_in    = S_RET;
         end
         S_RET: begin
            if (sp_ff == '0) begin
               state_in = S_DONE;
            end else if (!stk_ph_ff[top_ix]) begin
               ph_set   = 1'b1;
               nd_in    = t_child_b;
               lo_in    = t_mid + 1'b1;
               hi_in    = t_hi;
               state_in = S_ENTER;
            end else begin
               sp_in    = sp_m1;
               nd_in    = t_nd;
               lo_in    = t_lo;
               hi_in    = t_hi;
               state_in = (kind_ff == REQ_QUERY) ? S_RET : S_CMB_A;
            end
         end
         S_CMB_A: begin
            cmd.rd      = 1'b1;
            cmd.rd_addr = child_a[ADDR_W-1:0];
            state_in    = S_CMB_B;
         end
         S_CMB_B: begin
            cmd.load_node = 1'b1;
            cmd.rd        = 1'b1;
            cmd.rd_addr   = child_b[ADDR_W-1:0];
            state_in      = S_CMB_C;
         end
         S_CMB_C: begin
            cmd.add_sums = 1'b1;
            state_in     = S_CMB_D;
         end
         S_CMB_D: begin
            cmd.wr_sums = 1'b1;
            state_in    = S_RET;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase

      if (csr_we) begin
         if (csr_v == '0) count_in = CNT_W'(1);
         else if (32'(csr_v) > 32'(MAX_ELEMENTS)) count_in = CNT_W'(MAX_ELEMENTS);
         else count_in = CNT_W'(csr_v);
         clr_in   = '0;
         state_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= CNT_W'(MAX_ELEMENTS);
         sp_ff        <= '0;
         covered_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= REQ_NONE;
         next_ff      <= S_IDLE;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         sp_ff        <= sp_in;
         covered_ff   <= covered_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= kind_in;
         next_ff      <= next_in;
      end
      l_ff   <= l_in;
      r_ff   <= r_in;
      nd_ff  <= nd_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      pc_ff  <= pc_in;
      end_ff <= end_in;
      if (push) begin
         stk_nd_ff[push_ix] <= nd_ff;
         stk_lo_ff[push_ix] <= lo_ff;
         stk_hi_ff[push_ix] <= hi_ff;
         stk_ph_ff[push_ix] <= 1'b0;
      end
      if (ph_set) stk_ph_ff[top_ix] <= 1'b1;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule

### hw/rtl/range_add_cube_sum_tree_core.sv
// Lazy segment tree over residues mod 1000000007 with range add and
// cube-sum query.
// Request: start with req_type/left/right/operand, taken when busy is low.
//   Load writes one element, range add adds to a closed range, query returns
//   the cube sum of a closed range. Only queries give a result.
// Result: rsp_valid strobes for one cycle with rsp_cube_sum, in the cycle
//   that busy drops; the receiver cannot stall it, so nothing is held back.
// Config: csr_we/csr_wdata write the element count (clamped to 1..1024)
//   and then clear all node stores.
// Reset and every count write start a clearing pass over all 2048 nodes, one
//   node per cycle, with busy high.
// Walk: one request walks the tree depth first with an explicit stack,
//   visiting nodes and recombining each parent on updates.
//   A node with a nonzero pending addend costs one apply program: 11 modular
//   multiplies in a bit-serial unit and 6 adds. A request visits up to about
//   4 nodes per level over 11 levels.
`include "assert_macros.svh"
module range_add_cube_sum_tree_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [racst_pkg::TYPE_W-1:0]    req_type,
   input  logic [racst_pkg::REQ_IDX_W-1:0] req_left_index,
   input  logic [racst_pkg::REQ_IDX_W-1:0] req_right_index,
   input  logic [racst_pkg::VAL_W-1:0]     req_operand_value,
   output logic                            rsp_valid,
   output logic [racst_pkg::VAL_W-1:0]     rsp_cube_sum,
   input  logic                            csr_we,
   input  logic [racst_pkg::CSR_W-1:0]     csr_wdata
);
   import racst_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   racst_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_left_index  (req_left_index),
      .req_right_index (req_right_index),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .stat            (stat),
      .cmd             (cmd),
      .rsp_valid       (rsp_valid)
   );

   racst_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .operand  (req_operand_value),
      .stat     (stat),
      .cube_sum (rsp_cube_sum)
   );

   `ASSERT_IMPLY(a_rsp_when_idle, clock, reset, rsp_valid, !busy, "result while busy")
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result strobe too long")
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "transfer not started")
   `ASSERT_NEXT(a_csr_clear, clock, reset, csr_we, busy, "no clearing after count write")
endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import racst_pkg::*;

   localparam int unsigned P = 32'd1000000007;
   localparam int WATCHDOG_LIMIT = 200000;

   logic clock, reset, start, busy, rsp_valid, csr_we;
   logic [TYPE_W-1:0] req_type;
   logic [REQ_IDX_W-1:0] req_left_index, req_right_index;
   logic [VAL_W-1:0] req_operand_value, rsp_cube_sum;
   logic [CSR_W-1:0] csr_wdata;

   range_add_cube_sum_tree_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_left_index(req_left_index),
      .req_right_index(req_right_index), .req_operand_value(req_operand_value),
      .rsp_valid(rsp_valid), .rsp_cube_sum(rsp_cube_sum),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow tree
   int unsigned sum1_q [NODE_DEPTH];
   int unsigned sum2_q [NODE_DEPTH];
   int unsigned sum3_q [NODE_DEPTH];
   int unsigned addend_q [NODE_DEPTH];
   int unsigned elem_count;

   logic [VAL_W-1:0] cube_sums_due [$];
   int errors, n_load, n_add, n_query, n_other, n_cfg, idle_cycles;
   bit no_gaps;

   function automatic int unsigned add_m(int unsigned a, int unsigned b);
      return int'((longint'(a) + longint'(b)) % longint'(P));
   endfunction

   function automatic int unsigned mul_m(int unsigned a, int unsigned b);
      return int'((longint'(a) * longint'(b)) % longint'(P));
   endfunction

   function automatic void clear_tree();
      for (int i = 0; i < NODE_DEPTH; i++) begin
         sum1_q[i] = 0; sum2_q[i] = 0; sum3_q[i] = 0; addend_q[i] = 0;
      end
   endfunction

   function automatic void push_addend(int unsigned nd, int unsigned lo, int unsigned hi);
      int unsigned x, len, s1, s2, x2, x3, t;
      x = addend_q[nd];
      len = (hi - lo + 1) % P;
      s1 = sum1_q[nd];
      s2 = sum2_q[nd];
      x2 = mul_m(x, x);
      x3 = mul_m(x2, x);
      t = mul_m(mul_m(3, x), s2);
      t = add_m(t, mul_m(mul_m(3, s1), x2));
      t = add_m(t, mul_m(len, x3));
      sum3_q[nd] = add_m(sum3_q[nd], t);
      t = add_m(mul_m(mul_m(2, s1), x), mul_m(len, x2));
      sum2_q[nd] = add_m(s2, t);
      sum1_q[nd] = add_m(s1, mul_m(len, x));
      if (lo != hi && 2 * nd + 1 < NODE_DEPTH) begin
         addend_q[2*nd] = add_m(addend_q[2*nd], x);
         addend_q[2*nd+1] = add_m(addend_q[2*nd+1], x);
      end
      addend_q[nd] = 0;
   endfunction

   function automatic void update_span(int unsigned nd, int unsigned lo, int unsigned hi,
                                       int unsigned l, int unsigned r, int unsigned x,
                                       bit is_load);
      int unsigned mid;
      if (nd >= NODE_DEPTH) return;
      push_addend(nd, lo, hi);
      if (lo > r || hi < l) return;
      if (lo >= l && hi <= r) begin
         if (is_load) begin
            sum1_q[nd] = x;
            sum2_q[nd] = mul_m(x, x);
            sum3_q[nd] = mul_m(x, sum2_q[nd]);
         end else begin
            addend_q[nd] = x;
            push_addend(nd, lo, hi);
         end
         return;
      end
      if (2 * nd + 1 >= NODE_DEPTH) return;
      mid = (lo + hi) >> 1;
      update_span(2 * nd, lo, mid, l, r, x, is_load);
      update_span(2 * nd + 1, mid + 1, hi, l, r, x, is_load);
      sum1_q[nd] = add_m(sum1_q[2*nd], sum1_q[2*nd+1]);
      sum2_q[nd] = add_m(sum2_q[2*nd], sum2_q[2*nd+1]);
      sum3_q[nd] = add_m(sum3_q[2*nd], sum3_q[2*nd+1]);
   endfunction

   function automatic int unsigned span_cubes(int unsigned nd, int unsigned lo,
                                              int unsigned hi, int unsigned l,
                                              int unsigned r);
      int unsigned mid;
      if (nd >= NODE_DEPTH) return 0;
      push_addend(nd, lo, hi);
      if (r < lo || hi < l) return 0;
      if (l <= lo && hi <= r) return sum3_q[nd];
      if (2 * nd + 1 >= NODE_DEPTH) return 0;
      mid = (lo + hi) >> 1;
      return add_m(span_cubes(2 * nd, lo, mid, l, r),
                   span_cubes(2 * nd + 1, mid + 1, hi, l, r));
   endfunction

   // returns 1 and the cube sum for a query
   function automatic bit predict_cubes(logic [1:0] k, int unsigned l, int unsigned r,
                                        int unsigned v, output int unsigned s);
      int unsigned x, top;
      x = v % P;
      top = elem_count - 1;
      s = 0;
      case (req_kind_type'(k))
         REQ_LOAD: begin
            n_load++;
            if (l <= top) update_span(1, 0, top, l, l, x, 1'b1);
         end
         REQ_ADD: begin
            n_add++;
            if (l <= r) update_span(1, 0, top, l, r, x, 1'b0);
         end
         REQ_QUERY: begin
            n_query++;
            if (l <= r) s = span_cubes(1, 0, top, l, r);
            return 1'b1;
         end
         default: n_other++;
      endcase
      return 1'b0;
   endfunction

   task automatic send_req(logic [1:0] k, logic [9:0] l, logic [9:0] r, logic [29:0] v,
                           bit typed, logic [29:0] typed_sum);
      int gap;
      int unsigned s;
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_type <= k;
      req_left_index <= l;
      req_right_index <= r;
      req_operand_value <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (predict_cubes(k, 32'(l), 32'(r), 32'(v), s))
         cube_sums_due.push_back(typed ? typed_sum : s[29:0]);
   endtask

   task automatic set_count(logic [10:0] c);
      int unsigned cv;
      start <= 1'b0;
      @(posedge clock);
      while (cube_sums_due.size() != 0 || busy) @(posedge clock);
      repeat (40) @(posedge clock);
      while (busy) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= c;
      @(posedge clock);
      csr_we <= 1'b0;
      cv = 32'(c);
      if (cv < 1) cv = 1;
      if (cv > MAX_ELEMENTS) cv = MAX_ELEMENTS;
      elem_count = cv;
      clear_tree();
      n_cfg++;
   endtask

   task automatic random_phase(int items);
      logic [1:0] k;
      int unsigned l, r, v, top, sel;
      top = elem_count - 1;
      for (int i = 0; i < items; i++) begin
         if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         sel = $urandom_range(0, 99);
         k = sel < 35 ? REQ_LOAD : sel < 65 ? REQ_ADD : sel < 97 ? REQ_QUERY : REQ_NONE;
         l = $urandom_range(0, top);
         r = $urandom_range(l, top);
         sel = $urandom_range(0, 9);
         if (sel == 0) begin
            l = $urandom_range(0, 1023);
            r = $urandom_range(0, 1023);
         end else if (sel == 1) begin
            l = $urandom_range(0, top);
            r = l;
         end
         sel = $urandom_range(0, 9);
         if (sel == 0) v = $urandom_range(0, 32'h3FFF_FFFF);
         else if (sel == 1) v = P - 1;
         else if (sel == 2) v = $urandom_range(0, 3);
         else v = $urandom_range(0, P - 1);
         send_req(k, l[9:0], r[9:0], v[29:0], 1'b0, '0);
      end
   endtask

   typedef struct {
      logic [1:0] k;
      logic [9:0] l, r;
      logic [29:0] v;
      bit typed;
      logic [29:0] sum;
   } dir_row_type;

   dir_row_type dir_rows [] = '{
      '{REQ_QUERY, 10'd0, 10'd1023, 30'd0, 1'b1, 30'd0},
      '{REQ_LOAD, 10'd0, 10'd0, 30'd1000000006, 1'b0, 30'd0},
      '{REQ_QUERY, 10'd0, 10'd0, 30'd0, 1'b1, 30'd1000000006},
      '{REQ_LOAD, 10'd1023, 10'd0, 30'h3FFF_FFFF, 1'b0, 30'd0},
      '{REQ_QUERY, 10'd1023, 10'd1023, 30'd0, 1'b0, 30'd0},
      '{REQ_QUERY, 10'd1023, 10'd0, 30'd0, 1'b1, 30'd0},
      '{REQ_ADD, 10'd1023, 10'd0, 30'd5, 1'b0, 30'd0},
      '{REQ_NONE, 10'd0, 10'd1023, 30'd9, 1'b0, 30'd0},
      '{REQ_ADD, 10'd0, 10'd1023, 30'd1, 1'b0, 30'd0},
      '{REQ_QUERY, 10'd0, 10'd0, 30'd0, 1'b1, 30'd0},
      '{REQ_QUERY, 10'd0, 10'd1023, 30'd0, 1'b0, 30'd0},
      '{REQ_ADD, 10'd3, 10'd700, 30'h3FFF_FFFF, 1'b0, 30'd0},
      '{REQ_ADD, 10'd500, 10'd500, 30'd1000000006, 1'b0, 30'd0},
      '{REQ_LOAD, 10'd600, 10'd0, 30'd2, 1'b0, 30'd0},
      '{REQ_QUERY, 10'd2, 10'd601, 30'd0, 1'b0, 30'd0},
      '{REQ_QUERY, 10'd500, 10'd500, 30'd0, 1'b0, 30'd0},
      '{REQ_QUERY, 10'd0, 10'd1023, 30'd0, 1'b0, 30'd0}
   };

   dir_row_type small_rows [] = '{
      '{REQ_LOAD, 10'd1, 10'd0, 30'd7, 1'b0, 30'd0},
      '{REQ_ADD, 10'd0, 10'd1023, 30'd2, 1'b0, 30'd0},
      '{REQ_QUERY, 10'd0, 10'd1023, 30'd0, 1'b0, 30'd0},
      '{REQ_QUERY, 10'd1, 10'd1023, 30'd0, 1'b0, 30'd0},
      '{REQ_LOAD, 10'd1023, 10'd0, 30'd3, 1'b0, 30'd0},
      '{REQ_QUERY, 10'd0, 10'd0, 30'd0, 1'b0, 30'd0}
   };

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (cube_sums_due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected cube_sum transfer: %0d", rsp_cube_sum);
         end else begin
            if (rsp_cube_sum !== cube_sums_due[0]) begin
               errors++;
               if (errors <= 10)
                  $display("cube_sum mismatch: expected %0d actual %0d",
                           cube_sums_due[0], rsp_cube_sum);
            end
            void'(cube_sums_due.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("range_add_cube_sum_tree_core regression: fail");
         $finish;
      end
   end

   int unsigned phase_counts [] = '{11'd0, 11'd2047, 11'd2, 11'd3, 11'd7, 11'd16,
                                    11'd33, 11'd90, 11'd255, 11'd1024};
   int phase_items [] = '{70, 60, 150, 150, 180, 180, 160, 140, 90, 60};

   initial begin
      reset = 1'b1;
      start = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_type = '0;
      req_left_index = '0;
      req_right_index = '0;
      req_operand_value = '0;
      errors = 0; n_load = 0; n_add = 0; n_query = 0; n_other = 0; n_cfg = 0;
      idle_cycles = 0;
      no_gaps = 1'b0;
      elem_count = MAX_ELEMENTS;
      clear_tree();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i])
         send_req(dir_rows[i].k, dir_rows[i].l, dir_rows[i].r, dir_rows[i].v,
                  dir_rows[i].typed, dir_rows[i].sum);
      foreach (phase_counts[p]) begin
         set_count(phase_counts[p][10:0]);
         if (elem_count <= 2)
            foreach (small_rows[i])
               send_req(small_rows[i].k, small_rows[i].l, small_rows[i].r, small_rows[i].v,
                        small_rows[i].typed, small_rows[i].sum);
         random_phase(phase_items[p]);
      end
      start <= 1'b0;
      @(posedge clock);
      while (cube_sums_due.size() != 0 || busy) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d loads, %0d range adds, %0d queries, %0d unused requests",
               n_load, n_add, n_query, n_other);
      $display("over %0d element count settings, %0d mismatches", n_cfg + 1, errors);
      if (errors == 0 && cube_sums_due.size() == 0) begin
         $display("range_add_cube_sum_tree_core regression: pass");
      end else begin
         $display("range_add_cube_sum_tree_core regression: fail");
      end
      $finish;
   end
endmodule
